// ===== rtl/core/cfltm_pkg.sv =====
// Shared types, codes and constants for the CFL timestep reduction core.
`timescale 1ns / 1ps

package cfltm_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;
    localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [31:0] COEFF_RESET   = 32'd19661;

    // divisor chosen for the shared divide/sqrt unit
    typedef enum logic [1:0] {
        DEN_CS,
        DEN_TOT,
        DEN_GRV
    } den_sel_t;

    // operand pair for the multiplier
    typedef enum logic {
        MUL_FORCE,
        MUL_COEFF
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     sqrt_start;
        den_sel_t den_sel;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     fold_sound;
        logic     fold_accel;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic iter_done;
        logic ghost;
        logic last;
        logic cs_nz;
        logic at_nz;
        logic ag_nz;
    } status_t;

endpackage

// ===== rtl/core/cfltm_ctrl.sv =====
// Sequencer for one particle item: divides, square roots, folds, final emit.
`timescale 1ns / 1ps

module cfltm_ctrl
    import cfltm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SND_START,
        S_SND_WAIT,
        S_SND_FOLD,
        S_TOT_START,
        S_GRV_START,
        S_ACC_DIV_WAIT,
        S_ACC_SQRT_START,
        S_ACC_SQRT_WAIT,
        S_ACC_MUL,
        S_ACC_FOLD,
        S_FIN_START,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   grv_pass_reg, grv_pass_next;

    always_comb
    begin
        state_next    = state_reg;
        grv_pass_next = grv_pass_reg;
        cmd           = '0;
        cmd.den_sel   = DEN_CS;
        cmd.mul_sel   = MUL_FORCE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SND_START;
                end
            end
            S_SND_START:
            begin
                if (!status.ghost && status.cs_nz)
                begin
                    cmd.div_start = 1'b1;
                    cmd.den_sel   = DEN_CS;
                    state_next    = S_SND_WAIT;
                end
                else
                begin
                    state_next = S_TOT_START;
                end
            end
            S_SND_WAIT:
            begin
                if (status.iter_done)
                    state_next = S_SND_FOLD;
            end
            S_SND_FOLD:
            begin
                cmd.fold_sound = 1'b1;
                state_next     = S_TOT_START;
            end
            S_TOT_START:
            begin
                grv_pass_next = 1'b0;
                if (!status.ghost && status.at_nz)
                begin
                    cmd.div_start = 1'b1;
                    cmd.den_sel   = DEN_TOT;
                    state_next    = S_ACC_DIV_WAIT;
                end
                else
                begin
                    state_next = S_GRV_START;
                end
            end
            S_GRV_START:
            begin
                grv_pass_next = 1'b1;
                if (!status.ghost && status.ag_nz)
                begin
                    cmd.div_start = 1'b1;
                    cmd.den_sel   = DEN_GRV;
                    state_next    = S_ACC_DIV_WAIT;
                end
                else
                begin
                    state_next = S_FIN_START;
                end
            end
            S_ACC_DIV_WAIT:
            begin
                if (status.iter_done)
                    state_next = S_ACC_SQRT_START;
            end
            S_ACC_SQRT_START:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_ACC_SQRT_WAIT;
            end
            S_ACC_SQRT_WAIT:
            begin
                if (status.iter_done)
                    state_next = S_ACC_MUL;
            end
            S_ACC_MUL:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_FORCE;
                state_next    = S_ACC_FOLD;
            end
            S_ACC_FOLD:
            begin
                cmd.fold_accel = 1'b1;
                state_next     = grv_pass_reg ? S_FIN_START : S_GRV_START;
            end
            S_FIN_START:
            begin
                if (status.last)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_COEFF;
                    state_next    = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            grv_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            grv_pass_reg <= grv_pass_next;
        end
    end

endmodule

// ===== rtl/core/cfltm_dpath.sv =====
// Datapath: operand latches, shared divide/sqrt unit, multiplier, minima, result.
`timescale 1ns / 1ps

module cfltm_dpath
    import cfltm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_wr,
    input  logic [31:0] cfg_data,
    input  logic        ghost,
    input  logic [31:0] smoothing_length,
    input  logic [31:0] sound_speed,
    input  logic signed [31:0] total_accel,
    input  logic signed [31:0] gravity_accel,
    input  logic        last_particle,
    output logic [31:0] timestep,
    output logic        done
);

    localparam int unsigned NW  = 32 + FRAC_BITS;             // dividend / radicand width
    localparam int unsigned SW  = NW + (NW % 2);              // radicand padded to even
    localparam int unsigned HW  = SW / 2;                     // root width
    localparam int unsigned RW  = (HW + 3 > 33) ? HW + 3 : 33; // partial remainder width
    localparam int unsigned CW  = $clog2(NW + 1);
    localparam logic [31:0] FORCE_C =
        32'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

    // latched item
    logic [31:0] h_reg, cs_reg, at_reg, ag_reg;
    logic        ghost_reg, last_reg;

    // shared iterative unit
    logic          run_reg, sqrt_mode_reg, iter_done_reg;
    logic [CW-1:0] cnt_reg;
    logic [SW-1:0] opnd_reg;
    logic [RW-1:0] rem_reg;
    logic [NW-1:0] quo_reg;
    logic [31:0]   den_reg;
    logic [31:0]   res_reg;

    logic [RW-1:0] step_in, subtr;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rem_next;
    logic [NW-1:0] quo_next;
    logic [31:0]   quo_sat;

    // multiplier and reduction
    logic [31:0] coeff_reg, min_hcs_reg, min_acc_reg;
    logic [31:0] timestep_reg;
    logic        done_reg;
    logic [31:0] mul_a, mul_b, den_mux;
    logic [63:0] prod_reg, prod_sh;
    logic [31:0] prod_sat, ds, dt;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    assign status.iter_done = iter_done_reg;
    assign status.ghost     = ghost_reg;
    assign status.last      = last_reg;
    assign status.cs_nz     = (cs_reg != 32'd0);
    assign status.at_nz     = (at_reg != 32'd0);
    assign status.ag_nz     = (ag_reg != 32'd0);

    always_comb
    begin
        case (cmd.den_sel)
            DEN_CS:  den_mux = cs_reg;
            DEN_TOT: den_mux = at_reg;
            DEN_GRV: den_mux = ag_reg;
            default: den_mux = cs_reg;
        endcase
    end

    // one restoring step: a bit of quotient or a bit of root
    always_comb
    begin
        if (sqrt_mode_reg)
        begin
            step_in = {rem_reg[RW-3:0], opnd_reg[SW-1:SW-2]};
            subtr   = {quo_reg[RW-3:0], 2'b01};
        end
        else
        begin
            step_in = {rem_reg[RW-2:0], opnd_reg[SW-1]};
            subtr   = {{(RW-32){1'b0}}, den_reg};
        end
        diff     = {1'b0, step_in} - {1'b0, subtr};
        ge       = ~diff[RW];
        rem_next = ge ? diff[RW-1:0] : step_in;
        quo_next = {quo_reg[NW-2:0], ge};
        quo_sat  = (|quo_next[NW-1:32]) ? ALL_ONES : quo_next[31:0];
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_FORCE:
            begin
                mul_a = res_reg;
                mul_b = FORCE_C;
            end
            MUL_COEFF:
            begin
                mul_a = coeff_reg;
                mul_b = min_hcs_reg;
            end
            default:
            begin
                mul_a = res_reg;
                mul_b = FORCE_C;
            end
        endcase
    end

    assign prod_sh  = prod_reg >> FRAC_BITS;
    assign prod_sat = (|prod_sh[63:32]) ? ALL_ONES : prod_sh[31:0];
    assign ds       = (min_hcs_reg == ALL_ONES) ? ALL_ONES : prod_sat;
    assign dt       = (ds < min_acc_reg) ? ds : min_acc_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            sqrt_mode_reg <= 1'b0;
            iter_done_reg <= 1'b0;
            cnt_reg       <= '0;
            coeff_reg     <= COEFF_RESET;
            min_hcs_reg   <= ALL_ONES;
            min_acc_reg   <= ALL_ONES;
            done_reg      <= 1'b0;
        end
        else
        begin
            // pulse on the cycle after the last iteration
            iter_done_reg <= run_reg && (cnt_reg == CW'(1))
                             && !cmd.div_start && !cmd.sqrt_start;
            done_reg      <= cmd.emit;
            if (cfg_wr)
                coeff_reg <= cfg_data;
            if (cmd.div_start)
            begin
                run_reg       <= 1'b1;
                sqrt_mode_reg <= 1'b0;
                cnt_reg       <= CW'(NW);
            end
            else if (cmd.sqrt_start)
            begin
                run_reg       <= 1'b1;
                sqrt_mode_reg <= 1'b1;
                cnt_reg       <= CW'(HW);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    run_reg <= 1'b0;
            end
            if (cmd.emit)
            begin
                min_hcs_reg <= ALL_ONES;
                min_acc_reg <= ALL_ONES;
            end
            else
            begin
                if (cmd.fold_sound && (res_reg < min_hcs_reg))
                    min_hcs_reg <= res_reg;
                if (cmd.fold_accel && (prod_sat < min_acc_reg))
                    min_acc_reg <= prod_sat;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ghost_reg <= ghost;
            last_reg  <= last_particle;
            h_reg     <= smoothing_length;
            cs_reg    <= sound_speed;
            at_reg    <= mag32(total_accel);
            ag_reg    <= mag32(gravity_accel);
        end
        if (cmd.div_start)
        begin
            opnd_reg <= {h_reg, {(SW-32){1'b0}}};
            den_reg  <= den_mux;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (cmd.sqrt_start)
        begin
            opnd_reg <= SW'({res_reg, {FRAC_BITS{1'b0}}});
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (run_reg)
        begin
            opnd_reg <= sqrt_mode_reg ? {opnd_reg[SW-3:0], 2'b00}
                                      : {opnd_reg[SW-2:0], 1'b0};
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            if (cnt_reg == CW'(1))
                res_reg <= quo_sat;
        end
        if (cmd.mul_start)
            prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        if (cmd.emit)
            timestep_reg <= dt;
    end

    assign timestep = timestep_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/core/cfl_timestep_min_reduction_core.sv =====
// Top level of the CFL timestep minimum reduction core.
`timescale 1ns / 1ps
//
// Usage
//   Particles enter one item at a time: an item is taken at a rising edge with
//   start high and busy low. busy stays high while the item is worked on.
//   Items not marked last_particle give no result; the one marked last gives
//   one result: timestep on the result port, qualified by done for exactly one
//   cycle. The receiver cannot stall, so a result is never held.
//   The sound coefficient is written through cfg_valid/cfg_data; cfg_ready is
//   always high. Write it only while busy is low.
// Operation (Q16.16 at the default FRAC_BITS of 16)
//   Every division and square root runs in one shared restoring unit, one
//   quotient or root bit per cycle. A full non-ghost particle with every
//   constraint active takes the sound division and fold, then for each
//   acceleration a division, square root, multiply and fold; a particle
//   marked last then adds the final multiply and emit step. A ghost skips
//   every division and square root. done and timestep are registered from
//   the emit step, and done may coincide with the next item being taken.
// Reset
//   Both running minima go to all ones and the coefficient to 19661; no
//   clearing pass is needed.

module cfl_timestep_min_reduction_core
    import cfltm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               ghost,
    input  logic [31:0]        smoothing_length,
    input  logic [31:0]        sound_speed,
    input  logic signed [31:0] total_accel,
    input  logic signed [31:0] gravity_accel,
    input  logic               last_particle,
    output logic [31:0]        timestep,
    output logic               done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;

    // the coefficient register accepts a write every cycle
    assign cfg_ready = 1'b1;

    cfltm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    cfltm_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_wr           (cfg_valid && cfg_ready),
        .cfg_data         (cfg_data),
        .ghost            (ghost),
        .smoothing_length (smoothing_length),
        .sound_speed      (sound_speed),
        .total_accel      (total_accel),
        .gravity_accel    (gravity_accel),
        .last_particle    (last_particle),
        .timestep         (timestep),
        .done             (done)
    );

    // a taken item always occupies the sequencer in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but sequencer not busy");

    // a result comes only out of the emit step of a running item
    a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a running item");

    // at most one result per item: the done strobe is never repeated back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

endmodule
